FILE: src/mtf_pkg.sv
package mtf_pkg;

    // Recency list geometry.
    localparam int LIST_ENTRIES = 256;
    localparam int LIST_W       = $clog2(LIST_ENTRIES);
    localparam int COUNT_W      = LIST_W + 1;

    // The priority search splits the list into groups of this size.
    localparam int GRP_SIZE  = 16;
    localparam int GRP_W     = $clog2(GRP_SIZE);
    localparam int GRP_CNT   = LIST_ENTRIES / GRP_SIZE;
    localparam int GRP_CNT_W = $clog2(GRP_CNT);

    // Position codes: positions 0..256, so p+1 needs nine bits.
    localparam int POS_W  = 9;
    localparam int CODE_W = 12;
    localparam logic [POS_W-1:0] END_POS = 9'd256;

    // Capacity counter width.
    localparam int BYTES_W = 24;
    localparam logic [BYTES_W-1:0] MAX_BYTES_RST = 24'd65535;

    // Fibonacci weights 1, 2, 3, 5, ... 233.
    localparam logic [POS_W-1:0] FIB_WEIGHT [CODE_W] = '{
        9'd1, 9'd2, 9'd3, 9'd5, 9'd8, 9'd13,
        9'd21, 9'd34, 9'd55, 9'd89, 9'd144, 9'd233
    };

    // Broadcast control for the list cells.
    typedef struct packed {
        logic       shift;
        logic [7:0] key;
    } cell_ctl_t;

    // One coding request handed to the bit packer.
    typedef struct packed {
        logic             start;
        logic             is_end;
        logic             has_lit;
        logic [POS_W-1:0] pos;
        logic [7:0]       lit;
    } pack_job_t;

    // Packer status seen by the controller.
    typedef struct packed {
        logic busy;
        logic err;
    } pack_stat_t;

    // Half of the greedy Zeckendorf split.
    typedef struct packed {
        logic [POS_W-1:0] rem;
        logic [5:0]       bits;
    } zeck_part_t;

    // Greedy split over the upper or lower six weights.
    function automatic zeck_part_t zeck_half(logic [POS_W-1:0] v, logic upper);
        zeck_part_t       r;
        logic [POS_W-1:0] w;
        r.rem  = v;
        r.bits = '0;
        for (int k = 5; k >= 0; k--) begin
            w = upper ? FIB_WEIGHT[k + 6] : FIB_WEIGHT[k];
            if (r.rem >= w) begin
                r.bits[k] = 1'b1;
                r.rem     = r.rem - w;
            end
        end
        return r;
    endfunction

endpackage

FILE: src/mtf_cell.sv
module mtf_cell
    import mtf_pkg::*;
(
    input  logic       clk,
    input  cell_ctl_t  ctl,
    input  logic       valid,
    input  logic       take,
    input  logic [7:0] left_byte,
    output logic [7:0] cell_byte,
    output logic       match
);

    logic [7:0] byte_reg;

    // Compare the held byte against the search key.
    assign match     = valid && (byte_reg == ctl.key);
    assign cell_byte = byte_reg;

    // Move-to-front: cells at or before the found position take the left neighbor.
    always_ff @(posedge clk)
    begin
        if (ctl.shift && take)
        begin
            byte_reg <= left_byte;
        end
    end

endmodule

FILE: src/mtf_prio.sv
module mtf_prio
    import mtf_pkg::*;
(
    input  logic                    clk,
    input  logic [LIST_ENTRIES-1:0] match,
    output logic [LIST_W-1:0]       pos,
    output logic                    found
);

    logic [GRP_CNT-1:0] grp_any_next;
    logic [GRP_CNT-1:0] grp_any_reg;
    logic [GRP_W-1:0]   grp_idx_next [GRP_CNT];
    logic [GRP_W-1:0]   grp_idx_reg  [GRP_CNT];
    logic [GRP_CNT_W-1:0] grp_sel;

    // First level: lowest matching cell within each group.
    always_comb
    begin
        for (int g = 0; g < GRP_CNT; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int k = GRP_SIZE - 1; k >= 0; k--)
            begin
                if (match[g * GRP_SIZE + k])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = GRP_W'(k);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_any_reg <= grp_any_next;
        grp_idx_reg <= grp_idx_next;
    end

    // Second level: lowest group with a match.
    always_comb
    begin
        grp_sel = '0;
        for (int g = GRP_CNT - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                grp_sel = GRP_CNT_W'(g);
            end
        end
    end

    assign found = |grp_any_reg;
    assign pos   = {grp_sel, grp_idx_reg[grp_sel]};

endmodule

FILE: src/mtf_packer.sv
module mtf_packer
    import mtf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pack_job_t          job,
    input  logic [BYTES_W-1:0] max_bytes,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               overflow,
    output pack_stat_t         stat
);

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_C1    = 3'd1;
    localparam logic [2:0] P_C2    = 3'd2;
    localparam logic [2:0] P_BUILD = 3'd3;
    localparam logic [2:0] P_EMIT  = 3'd4;

    localparam int W_W   = CODE_W + 1 + 8;
    localparam int ACC_W = W_W + 7;
    localparam int N_W   = $clog2(ACC_W + 8);

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic               err_reg;
    logic [7:0]         bits_reg;
    logic [2:0]         bc_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               last_reg;
    logic               ovf_reg;

    logic               end_reg;
    logic               has_lit_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [7:0]         lit_reg;
    logic [POS_W-1:0]   rem_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [N_W-1:0]     n_reg;

    zeck_part_t         zh;
    zeck_part_t         zl;
    logic [3:0]         len_c;
    logic [W_W-1:0]     word;
    logic [7:0]         buf_top;
    logic [ACC_W-1:0]   acc_next;
    logic [N_W-1:0]     n_raw;
    logic [N_W-1:0]     n_next;
    logic               emit_now;
    logic               finish;
    logic               cap_hit;
    logic [7:0]         bits_save;

    // Zeckendorf split of p+1, upper weights then lower weights.
    assign zh = zeck_half(pos_reg + 9'd1, 1'b1);
    assign zl = zeck_half(rem_reg, 1'b0);

    // Build the new bit string: code bits lowest weight first, stop bit, literal.
    always_comb
    begin
        len_c = 4'd1;
        for (int k = 0; k < CODE_W; k++)
        begin
            if (code_reg[k])
            begin
                len_c = 4'(k + 1);
            end
        end
        word = '0;
        for (int k = 0; k < CODE_W; k++)
        begin
            word[W_W - 1 - k] = code_reg[k];
        end
        word = word | (W_W'(1) << (5'(W_W - 1) - {1'b0, len_c}));
        if (has_lit_reg)
        begin
            word = word | (W_W'(lit_reg) << (5'(CODE_W) - {1'b0, len_c}));
        end
        buf_top  = 8'(bits_reg << (4'd8 - {1'b0, bc_reg}));
        acc_next = {buf_top, (ACC_W - 8)'(0)} | ({word, 7'b0} >> bc_reg);
        n_raw    = N_W'(bc_reg) + N_W'(len_c) + N_W'(1) + (has_lit_reg ? N_W'(8) : N_W'(0));
        n_next   = end_reg ? ((n_raw + N_W'(7)) & ~N_W'(7)) : n_raw;
    end

    // Byte emission toward the output register.
    assign finish    = err_reg || (n_reg < N_W'(8));
    assign emit_now  = (state_reg == P_EMIT) && !finish && (!out_valid_reg || !out_stall);
    assign cap_hit   = bytes_reg >= max_bytes;
    assign bits_save = 8'(acc_reg[ACC_W-1 -: 8] >> (4'd8 - {1'b0, n_reg[2:0]}));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            P_IDLE:
            begin
                if (job.start && !(job.is_end && err_reg))
                begin
                    state_next = P_C1;
                end
            end
            P_C1:    state_next = P_C2;
            P_C2:    state_next = P_BUILD;
            P_BUILD: state_next = P_EMIT;
            P_EMIT:
            begin
                if (finish)
                begin
                    state_next = P_IDLE;
                end
            end
            default: state_next = P_IDLE;
        endcase
    end

    // Control and stream state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= P_IDLE;
            err_reg       <= 1'b0;
            bits_reg      <= '0;
            bc_reg        <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == P_IDLE && job.start && job.is_end && err_reg)
            begin
                err_reg   <= 1'b0;
                bits_reg  <= '0;
                bc_reg    <= '0;
                bytes_reg <= '0;
            end
            if (state_reg == P_EMIT && finish)
            begin
                if (end_reg)
                begin
                    err_reg   <= 1'b0;
                    bits_reg  <= '0;
                    bc_reg    <= '0;
                    bytes_reg <= '0;
                end
                else if (!err_reg)
                begin
                    bits_reg <= bits_save;
                    bc_reg   <= n_reg[2:0];
                end
            end
            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
                if (cap_hit)
                begin
                    err_reg <= 1'b1;
                end
                else
                begin
                    bytes_reg <= bytes_reg + 24'd1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload and working registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == P_IDLE && job.start)
        begin
            end_reg     <= job.is_end;
            has_lit_reg <= job.has_lit;
            pos_reg     <= job.pos;
            lit_reg     <= job.lit;
        end
        if (state_reg == P_C1)
        begin
            rem_reg               <= zh.rem;
            code_reg[CODE_W-1:6]  <= zh.bits;
        end
        if (state_reg == P_C2)
        begin
            code_reg[5:0] <= zl.bits;
        end
        if (state_reg == P_BUILD)
        begin
            acc_reg <= acc_next;
            n_reg   <= n_next;
        end
        if (emit_now)
        begin
            acc_reg <= acc_reg << 8;
            n_reg   <= n_reg - N_W'(8);
            if (cap_hit)
            begin
                out_byte_reg <= 8'h00;
                last_reg     <= 1'b1;
                ovf_reg      <= 1'b1;
            end
            else
            begin
                out_byte_reg <= acc_reg[ACC_W-1 -: 8];
                last_reg     <= end_reg && (n_reg == N_W'(8));
                ovf_reg      <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign overflow  = ovf_reg;
    assign stat.busy = (state_reg != P_IDLE);
    assign stat.err  = err_reg;

endmodule

FILE: src/mtf_fibonacci_encoder.sv
// Channel  Signals                          Moves
// -------  -------------------------------  -----------------------------------
// in       in_valid, in_stall, op,          one request: a source byte or end
//          data_byte
// out      out_valid, out_stall, out_byte,  one packed byte or an overflow mark
//          last, overflow
// cfg      cfg_wr_en, cfg_wr_data           max_output_bytes
//
// A source request is accepted in ST_IDLE, searched in ST_SRCH1 (compare
// with group encode) and ST_SRCH2 (pick and shift), coded in the packer states
// P_C1, P_C2 and P_BUILD, and emitted from P_EMIT at one output byte per cycle
// while the output does not stall; the controller waits in ST_WAIT until the
// packer is idle. The end request skips the search states. Reset
// clears the list fill count and the stream state; list cells hold no reset
// value and are read only below the fill count. A stall with a byte pending
// holds the byte register and pauses emission for as long as it stalls.
module mtf_fibonacci_encoder
    import mtf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               overflow,
    input  logic               cfg_wr_en,
    input  logic [BYTES_W-1:0] cfg_wr_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SRCH1 = 2'd1;
    localparam logic [1:0] ST_SRCH2 = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [BYTES_W-1:0]  max_reg;
    logic [7:0]          key_reg;

    logic                in_acc;
    cell_ctl_t           ctl;
    pack_job_t           job;
    pack_stat_t          stat;
    logic [LIST_ENTRIES-1:0] match;
    logic [7:0]          cell_byte [LIST_ENTRIES];
    logic [LIST_W-1:0]   hit_pos;
    logic                found;
    logic                full;
    logic [LIST_W-1:0]   shift_pos;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign full     = count_reg[COUNT_W-1];

    // A new byte shifts in up to the free cell; a full list always hits.
    assign shift_pos = found ? hit_pos : (full ? LIST_W'(LIST_ENTRIES - 1)
                                              : count_reg[LIST_W-1:0]);

    assign ctl.key   = key_reg;
    assign ctl.shift = (state_reg == ST_SRCH2);

    // Row of list cells, cell 0 at the front.
    for (genvar i = 0; i < LIST_ENTRIES; i++)
    begin : g_cell
        mtf_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .valid     (COUNT_W'(i) < count_reg),
            .take      (LIST_W'(i) <= shift_pos),
            .left_byte ((i == 0) ? key_reg : cell_byte[(i == 0) ? 0 : i - 1]),
            .cell_byte (cell_byte[i]),
            .match     (match[i])
        );
    end

    mtf_prio u_prio (
        .clk   (clk),
        .match (match),
        .pos   (hit_pos),
        .found (found)
    );

    // Coding request: from the search result, or the end code.
    always_comb
    begin
        job.start   = 1'b0;
        job.is_end  = 1'b0;
        job.has_lit = 1'b0;
        job.pos     = END_POS;
        job.lit     = key_reg;
        if (state_reg == ST_SRCH2)
        begin
            job.start   = 1'b1;
            job.has_lit = !found;
            job.pos     = found ? POS_W'(hit_pos) : POS_W'(count_reg);
        end
        else if (in_acc && op)
        begin
            job.start  = 1'b1;
            job.is_end = 1'b1;
        end
    end

    mtf_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .max_bytes (max_reg),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last),
        .overflow  (overflow),
        .stat      (stat)
    );

    // Request sequencing.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (op)
                    begin
                        state_next = ST_WAIT;
                    end
                    else if (!stat.err)
                    begin
                        state_next = ST_SRCH1;
                    end
                end
            end
            ST_SRCH1: state_next = ST_SRCH2;
            ST_SRCH2: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            max_reg   <= MAX_BYTES_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
            if (in_acc && op)
            begin
                count_reg <= '0;
            end
            else if (state_reg == ST_SRCH2 && !found && !full)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
    end

    // Search key.
    always_ff @(posedge clk)
    begin
        if (in_acc && !op)
        begin
            key_reg <= data_byte;
        end
    end

endmodule
